// ===== hw/rtl/qrdmp_pkg.sv =====
package qrdmp_pkg;

    localparam int COORD_W         = 8;
    localparam int VER_W           = 6;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 8;
    localparam int DEF_MAX_VERSION = 40;
    localparam int DEF_ALIGN_SLOTS = 7;
    localparam int SIDE_BASE       = 17;
    localparam int FINDER_SPAN     = 9;
    localparam int TIMING_LINE     = 6;
    localparam int ALIGN_HALF      = 2;
    localparam int ALIGN_NEAR      = 10;
    localparam int VERSION_AREA_V  = 7;
    localparam int VERSION_AREA_R  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_VERSION    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_BASE = CFG_IDX_W'(1);

    localparam logic [VER_W-1:0]   VER_RESET  = VER_W'(1);
    localparam logic [COORD_W-1:0] SIDE_RESET = COORD_W'(4 * 1 + SIDE_BASE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_FOLLOW
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pos_t;

    typedef struct packed {
        logic [COORD_W-1:0] side;
        logic               ver_ge7;
    } sym_t;

    typedef struct packed {
        logic               restart;
        logic [COORD_W-1:0] side;
    } walk_ctl_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               up;
        logic               right;
        logic               full;
    } walk_t;

    function automatic logic [COORD_W-1:0] side_of(input logic [VER_W-1:0] ver);
        logic [COORD_W-1:0] v8;
        v8 = COORD_W'(ver);
        return (v8 << 2) + COORD_W'(SIDE_BASE);
    endfunction

    function automatic walk_t walk_restart(input logic [COORD_W-1:0] side);
        walk_t w;
        w.col   = side - COORD_W'(2);
        w.row   = side - COORD_W'(1);
        w.up    = 1'b1;
        w.right = 1'b1;
        w.full  = 1'b0;
        return w;
    endfunction

    function automatic walk_t walk_advance(input walk_t cur, input logic [COORD_W-1:0] side);
        walk_t w;
        logic  step_pair;
        w         = cur;
        step_pair = 1'b0;
        if (!cur.right)
        begin
            if (cur.up)
            begin
                if (cur.row == '0)
                begin
                    w.up      = 1'b0;
                    step_pair = 1'b1;
                end
                else
                begin
                    w.row = cur.row - COORD_W'(1);
                end
            end
            else
            begin
                if (cur.row == side - COORD_W'(1))
                begin
                    w.up      = 1'b1;
                    step_pair = 1'b1;
                end
                else
                begin
                    w.row = cur.row + COORD_W'(1);
                end
            end
        end
        if (step_pair)
        begin
            if (cur.col < COORD_W'(2))
            begin
                w.full = 1'b1;
            end
            else
            begin
                w.col = cur.col - COORD_W'(2);
            end
        end
        // column 6 holds the vertical timing line
        if (w.col == COORD_W'(TIMING_LINE - 1))
        begin
            w.col = COORD_W'(TIMING_LINE - 2);
        end
        w.right = !cur.right;
        return w;
    endfunction

endpackage

// ===== hw/rtl/qrdmp_if.sv =====
interface qrdmp_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic restart_walk;

    modport source (output valid, output data_bit, output restart_walk, input ready);
    modport sink   (input valid, input data_bit, input restart_walk, output ready);
endinterface

interface qrdmp_out_if;
    logic                        valid;
    logic                        ready;
    logic [qrdmp_pkg::COORD_W-1:0] module_col;
    logic [qrdmp_pkg::COORD_W-1:0] module_row;
    logic                        module_dark;
    logic                        last_module;
    logic                        overflow;

    modport source (output valid, output module_col, output module_row, output module_dark,
                    output last_module, output overflow, input ready);
    modport sink   (input valid, input module_col, input module_row, input module_dark,
                    input last_module, input overflow, output ready);
endinterface

// ===== hw/rtl/qrdmp_resv.sv =====
module qrdmp_resv #(
    parameter int ALIGN_SLOTS = qrdmp_pkg::DEF_ALIGN_SLOTS
) (
    input  qrdmp_pkg::pos_t                                 pos,
    input  qrdmp_pkg::sym_t                                 sym,
    input  logic [ALIGN_SLOTS-1:0][qrdmp_pkg::COORD_W-1:0] coord,
    output logic                                            resv
);

    localparam int W9 = qrdmp_pkg::COORD_W + 1;

    always_comb
    begin
        logic [W9-1:0] c9;
        logic [W9-1:0] r9;
        logic [W9-1:0] s9;
        logic [W9-1:0] x9;
        logic          used;
        logic          near_lo;
        logic          near_hi;
        logic          c_hit;
        logic          r_hit;
        logic          col_mid;
        logic          col_lo;
        logic          col_hi;
        logic          row_mid;
        logic          row_lo;
        logic          row_hi;
        logic          fixed;
        logic          ver_area;
        logic          align;

        c9 = W9'(pos.col);
        r9 = W9'(pos.row);
        s9 = W9'(sym.side);
        col_mid = 1'b0;
        col_lo  = 1'b0;
        col_hi  = 1'b0;
        row_mid = 1'b0;
        row_lo  = 1'b0;
        row_hi  = 1'b0;

        for (int i = 0; i < ALIGN_SLOTS; i++)
        begin
            x9      = W9'(coord[i]);
            used    = (coord[i] != '0);
            near_lo = (x9 < W9'(qrdmp_pkg::ALIGN_NEAR));
            near_hi = (x9 + W9'(qrdmp_pkg::ALIGN_NEAR) > s9);
            c_hit   = used && (c9 + W9'(qrdmp_pkg::ALIGN_HALF) >= x9)
                      && (c9 <= x9 + W9'(qrdmp_pkg::ALIGN_HALF));
            r_hit   = used && (r9 + W9'(qrdmp_pkg::ALIGN_HALF) >= x9)
                      && (r9 <= x9 + W9'(qrdmp_pkg::ALIGN_HALF));
            col_lo  = col_lo  | (c_hit & near_lo);
            col_hi  = col_hi  | (c_hit & near_hi);
            col_mid = col_mid | (c_hit & !near_lo & !near_hi);
            row_lo  = row_lo  | (r_hit & near_lo);
            row_hi  = row_hi  | (r_hit & near_hi);
            row_mid = row_mid | (r_hit & !near_lo & !near_hi);
        end

        // centers next to a finder are dropped
        align = (col_mid & (row_mid | row_lo | row_hi))
              | (col_lo & row_mid)
              | (col_hi & (row_mid | row_hi));

        fixed = (c9 < W9'(qrdmp_pkg::FINDER_SPAN) && r9 < W9'(qrdmp_pkg::FINDER_SPAN))
              || (c9 + W9'(8) >= s9 && r9 < W9'(qrdmp_pkg::FINDER_SPAN))
              || (c9 < W9'(qrdmp_pkg::FINDER_SPAN) && r9 + W9'(8) >= s9)
              || (c9 == W9'(qrdmp_pkg::TIMING_LINE))
              || (r9 == W9'(qrdmp_pkg::TIMING_LINE));

        ver_area = sym.ver_ge7
                   && (((c9 + W9'(11) >= s9) && (c9 + W9'(9) <= s9)
                        && (r9 <= W9'(qrdmp_pkg::VERSION_AREA_R)))
                    || ((r9 + W9'(11) >= s9) && (r9 + W9'(9) <= s9)
                        && (c9 <= W9'(qrdmp_pkg::VERSION_AREA_R))));

        resv = fixed | ver_area | align;
    end

endmodule

// ===== hw/rtl/qrdmp_seq.sv =====
module qrdmp_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    qrdmp_in_if.sink                       data,
    qrdmp_out_if.source                    placed,
    input  qrdmp_pkg::walk_ctl_t           ctl,
    input  logic [qrdmp_pkg::COORD_W-1:0] side,
    output qrdmp_pkg::pos_t                cur_pos,
    input  logic                           resv
);

    localparam int CW = qrdmp_pkg::COORD_W;

    qrdmp_pkg::state_t state_reg, state_next;
    qrdmp_pkg::walk_t  walk_reg, walk_next;
    logic              bit_reg, bit_next;
    logic [CW-1:0]     pcol_reg, pcol_next;
    logic [CW-1:0]     prow_reg, prow_next;
    logic              ovalid_reg, ovalid_next;
    logic [CW-1:0]     ocol_reg, ocol_next;
    logic [CW-1:0]     orow_reg, orow_next;
    logic              odark_reg, odark_next;
    logic              olast_reg, olast_next;
    logic              oovf_reg, oovf_next;
    logic              out_free;

    assign cur_pos.col = walk_reg.right ? walk_reg.col + CW'(1) : walk_reg.col;
    assign cur_pos.row = walk_reg.row;
    assign out_free    = !ovalid_reg || placed.ready;

    assign data.ready         = (state_reg == qrdmp_pkg::ST_IDLE);
    assign placed.valid       = ovalid_reg;
    assign placed.module_col  = ocol_reg;
    assign placed.module_row  = orow_reg;
    assign placed.module_dark = odark_reg;
    assign placed.last_module = olast_reg;
    assign placed.overflow    = oovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= qrdmp_pkg::ST_IDLE;
            walk_reg   <= qrdmp_pkg::walk_restart(qrdmp_pkg::SIDE_RESET);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            walk_reg   <= walk_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg   <= bit_next;
        pcol_reg  <= pcol_next;
        prow_reg  <= prow_next;
        ocol_reg  <= ocol_next;
        orow_reg  <= orow_next;
        odark_reg <= odark_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
    end

    always_comb
    begin
        logic load;
        state_next = state_reg;
        walk_next  = walk_reg;
        bit_next   = bit_reg;
        pcol_next  = pcol_reg;
        prow_next  = prow_reg;
        ocol_next  = ocol_reg;
        orow_next  = orow_reg;
        odark_next = odark_reg;
        olast_next = olast_reg;
        oovf_next  = oovf_reg;
        load       = 1'b0;

        unique case (state_reg)
            qrdmp_pkg::ST_IDLE:
            begin
                if (data.valid)
                begin
                    bit_next   = data.data_bit;
                    state_next = qrdmp_pkg::ST_SEEK;
                    if (data.restart_walk)
                    begin
                        walk_next = qrdmp_pkg::walk_restart(side);
                    end
                end
                else if (ctl.restart)
                begin
                    walk_next = qrdmp_pkg::walk_restart(ctl.side);
                end
            end
            qrdmp_pkg::ST_SEEK:
            begin
                if (walk_reg.full)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        ocol_next  = '0;
                        orow_next  = '0;
                        odark_next = 1'b0;
                        olast_next = 1'b0;
                        oovf_next  = 1'b1;
                        state_next = qrdmp_pkg::ST_IDLE;
                    end
                end
                else if (!resv)
                begin
                    pcol_next  = cur_pos.col;
                    prow_next  = cur_pos.row;
                    walk_next  = qrdmp_pkg::walk_advance(walk_reg, side);
                    state_next = qrdmp_pkg::ST_FOLLOW;
                end
                else
                begin
                    walk_next = qrdmp_pkg::walk_advance(walk_reg, side);
                end
            end
            qrdmp_pkg::ST_FOLLOW:
            begin
                // park on the next free module so last_module is known
                if (walk_reg.full || !resv)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        ocol_next  = pcol_reg;
                        orow_next  = prow_reg;
                        odark_next = bit_reg;
                        olast_next = walk_reg.full;
                        oovf_next  = 1'b0;
                        state_next = qrdmp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    walk_next = qrdmp_pkg::walk_advance(walk_reg, side);
                end
            end
            default:
            begin
                state_next = qrdmp_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            ovalid_next = 1'b1;
        end
        else if (placed.ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        data.valid && data.ready |=> state_reg != qrdmp_pkg::ST_IDLE)
        else $error("accepted beat did not start a walk");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && oovf_reg |-> !olast_reg && ocol_reg == '0 && orow_reg == '0)
        else $error("overflow beat carries a module");

    a_last_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) && olast_reg |-> walk_reg.full)
        else $error("last module flagged with free modules left");

    a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
        !walk_reg.full |-> cur_pos.col < side && cur_pos.row < side)
        else $error("walk left the symbol");

endmodule

// ===== hw/rtl/qr_data_module_placer.sv =====
// QR data module placer.
// Channels: data (sink) takes one beat per data bit with data_bit and
// restart_walk; placed (source) gives one beat per data bit with the module
// column/row, its color, last_module and overflow. Config is a plain write
// port (cfg_we, cfg_index, cfg_data): index 0 is the version, 1.. the
// alignment center coordinates. A version write restarts the walk when idle.
// Operation: a beat is taken, then the walker checks one module per cycle
// through the shared reserved-area unit: it first steps past reserved
// modules to the free one for the bit, then moves on until it parks on the
// next free one or the walk is full; the result is loaded into the output
// register as it parks. A full walk while seeking gives an overflow beat
// instead. A beat taken with a version write has priority over its restart.
// data.ready is high only while the walker is idle; it returns as soon as
// the result sits in the output register, even if placed is stalled.
// If placed stalls with a result already held, the walker holds its parked
// position until the register frees up.
// Reset: version 1, no alignment squares, walk at the bottom right, no
// result pending.
module qr_data_module_placer #(
    parameter int MAX_VERSION = qrdmp_pkg::DEF_MAX_VERSION,
    parameter int ALIGN_SLOTS = qrdmp_pkg::DEF_ALIGN_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    qrdmp_in_if.sink                          data,
    qrdmp_out_if.source                       placed,
    input  logic                              cfg_we,
    input  logic [qrdmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qrdmp_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int VW = qrdmp_pkg::VER_W;
    localparam int CW = qrdmp_pkg::COORD_W;

    logic [VW-1:0]                ver_reg, ver_next;
    logic [ALIGN_SLOTS-1:0][CW-1:0] coord_reg;
    logic [VW-1:0]                ver_wr;
    qrdmp_pkg::walk_ctl_t         ctl;
    qrdmp_pkg::sym_t              sym;
    qrdmp_pkg::pos_t              cur_pos;
    logic                         resv;

    always_comb
    begin
        ver_wr = cfg_data[VW-1:0];
        if (ver_wr == '0)
        begin
            ver_wr = VW'(1);
        end
        else if (ver_wr > VW'(MAX_VERSION))
        begin
            ver_wr = VW'(MAX_VERSION);
        end
        ver_next = ver_reg;
        if (cfg_we && cfg_index == qrdmp_pkg::CFG_VERSION)
        begin
            ver_next = ver_wr;
        end
    end

    assign ctl.restart = cfg_we && (cfg_index == qrdmp_pkg::CFG_VERSION);
    assign ctl.side    = qrdmp_pkg::side_of(ver_wr);
    assign sym.side    = qrdmp_pkg::side_of(ver_reg);
    assign sym.ver_ge7 = (ver_reg >= VW'(qrdmp_pkg::VERSION_AREA_V));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ver_reg <= qrdmp_pkg::VER_RESET;
        end
        else
        begin
            ver_reg <= ver_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < ALIGN_SLOTS; i++)
            begin
                if (cfg_we && cfg_index == qrdmp_pkg::CFG_ALIGN_BASE
                    + qrdmp_pkg::CFG_IDX_W'(i))
                begin
                    coord_reg[i] <= cfg_data[CW-1:0];
                end
            end
        end
    end

    qrdmp_resv #(
        .ALIGN_SLOTS (ALIGN_SLOTS)
    ) u_resv (
        .pos   (cur_pos),
        .sym   (sym),
        .coord (coord_reg),
        .resv  (resv)
    );

    qrdmp_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .data    (data),
        .placed  (placed),
        .ctl     (ctl),
        .side    (sym.side),
        .cur_pos (cur_pos),
        .resv    (resv)
    );

endmodule
